// ===== design/jsd_pkg.sv =====
// ---------------------------------------------------------------------------
// jsd_pkg: shared types and constants for the two-server job dispatcher
// Job slot format, cell control bundle, server codes and time helpers.
// ---------------------------------------------------------------------------
package jsd_pkg;

    localparam int MAX_JOBS    = 64;
    localparam int ARR_W       = 10;
    localparam int TAG_W       = 8;
    localparam int LEN_W       = 10;
    localparam int TIME_W      = 17;
    localparam int CHOICE_W    = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [ARR_W-1:0]    CLOSE_RESET = ARR_W'(480);
    localparam logic [TIME_W-1:0]   TIME_MAX    = {TIME_W{1'b1}};

    localparam logic [CHOICE_W-1:0] SRV_FIRST   = 2'd0;
    localparam logic [CHOICE_W-1:0] SRV_SECOND  = 2'd1;
    localparam logic [CHOICE_W-1:0] SRV_REJECT  = 2'd2;

    // register index: bits above the byte offset
    localparam logic REG_CLOSE_TIME = 1'b0;

    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] length;
    } t_job;

    typedef struct packed {
        logic insert;   // sorted insert of the new job
        logic pop;      // shift toward the head, head leaves
    } t_cell_ctl;

    // saturating free-time update
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] base,
                                                  input logic [LEN_W-1:0]  dur);
        logic [TIME_W:0] s;
        s = {1'b0, base} + {{(TIME_W+1-LEN_W){1'b0}}, dur};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

// ===== design/jsd_cell.sv =====
// ---------------------------------------------------------------------------
// jsd_cell: one slot of the sorted job chain
// Keeps its job, takes the new job, or takes its upstream neighbor's job on
// insert; takes its downstream neighbor's job on pop.
// ---------------------------------------------------------------------------
module jsd_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jsd_pkg::t_cell_ctl i_ctl,
    input  jsd_pkg::t_job     i_new_job,
    input  jsd_pkg::t_job     i_prev_job,
    input  logic              i_prev_valid,
    input  logic              i_prev_le,
    input  jsd_pkg::t_job     i_next_job,
    input  logic              i_next_valid,
    output jsd_pkg::t_job     o_job,
    output logic              o_valid,
    output logic              o_le
);
    import jsd_pkg::*;

    t_job r_job, n_job;
    logic r_valid, n_valid;

    // stored job sorts at or before the new one
    assign o_le    = r_valid && (r_job.arrival <= i_new_job.arrival);
    assign o_job   = r_job;
    assign o_valid = r_valid;

    always_comb begin
        n_job   = r_job;
        n_valid = r_valid;
        if (i_ctl.pop) begin
            n_job   = i_next_job;
            n_valid = i_next_valid;
        end else if (i_ctl.insert && !o_le) begin
            if (i_prev_le) begin
                n_job   = i_new_job;
                n_valid = 1'b1;
            end else begin
                n_job   = i_prev_job;
                n_valid = i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

endmodule

// ===== design/jsd_server.sv =====
// ---------------------------------------------------------------------------
// jsd_server: server assignment and result register
// Tracks both servers' free times and places the head job of the chain.
// ---------------------------------------------------------------------------
module jsd_server (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  logic                            i_pop,
    input  jsd_pkg::t_job                   i_job,
    input  logic                            i_last,
    input  logic [jsd_pkg::ARR_W-1:0]       i_close_time,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [jsd_pkg::TAG_W-1:0]       o_result_tag,
    output logic [jsd_pkg::CHOICE_W-1:0]    o_server_choice,
    output logic [jsd_pkg::TIME_W-1:0]      o_service_start,
    output logic                            o_last_result
);
    import jsd_pkg::*;

    logic [TIME_W-1:0]   r_free0, r_free1, n_free0, n_free1;
    logic [CHOICE_W-1:0] n_choice;
    logic [TIME_W-1:0]   n_start;
    logic [ARR_W:0]      end_time;
    logic [TIME_W-1:0]   arr17;
    logic                r_valid;

    assign end_time = {1'b0, i_job.arrival} + {{(ARR_W+1-LEN_W){1'b0}}, i_job.length};
    assign arr17    = {{(TIME_W-ARR_W){1'b0}}, i_job.arrival};

    always_comb begin
        n_free0  = r_free0;
        n_free1  = r_free1;
        n_choice = SRV_REJECT;
        n_start  = '0;
        if (end_time > {1'b0, i_close_time}) begin
            n_choice = SRV_REJECT;
        end else if (arr17 >= r_free0) begin
            n_choice = SRV_FIRST;
            n_start  = arr17;
            n_free0  = sat_add(arr17, i_job.length);
        end else if (r_free0 <= r_free1) begin
            n_choice = SRV_FIRST;
            n_start  = r_free0;
            n_free0  = sat_add(r_free0, i_job.length);
        end else if (arr17 >= r_free1) begin
            n_choice = SRV_SECOND;
            n_start  = arr17;
            n_free1  = sat_add(arr17, i_job.length);
        end else begin
            n_choice = SRV_SECOND;
            n_start  = r_free1;
            n_free1  = sat_add(r_free1, i_job.length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free0 <= '0;
            r_free1 <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_free0 <= '0;
                r_free1 <= '0;
            end else if (i_pop) begin
                r_free0 <= n_free0;
                r_free1 <= n_free1;
            end
            if (i_pop) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (i_pop) begin
            o_result_tag    <= i_job.tag;
            o_server_choice <= n_choice;
            o_service_start <= n_start;
            o_last_result   <= i_last;
        end
    end

    assign o_out_valid = r_valid;

endmodule

// ===== design/two_server_job_dispatch_core.sv =====
// ---------------------------------------------------------------------------
// two_server_job_dispatch_core: sorted job loader and two-server dispatcher
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): each request is a job
//    (arrival, tag, length) or, with i_end_of_batch high, a batch end.
//    Jobs of length zero, and jobs arriving while all MAX_JOBS slots are
//    full, are dropped silently.
//  - Loading: each accepted job request makes the cell chain shift to
//    insert it after every stored job with an equal or earlier arrival.
//  - Dispatch: a batch end sets the busy flag and starts a walk of the
//    chain. Each pop moves the head job into the output register and the
//    chain one slot headward: one result per cycle unless the receiver stalls.
//    o_last_result marks the final result. An empty batch gives no results.
//  - While a batch is dispatching o_in_ready is low; it rises as the final
//    result enters the output register, even if that result still waits
//    for the receiver.
//  - Receiver stall: the result register holds; the chain stops shifting.
//  - Reset (i_rst_n, synchronous, low): all slots empty, both server free
//    times zero, close_time back to 480. No memory clearing pass.
//  - Configuration (APB): close_time at byte address 0; write it only
//    while idle. pready is always high.
// ---------------------------------------------------------------------------
module two_server_job_dispatch_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [jsd_pkg::ARR_W-1:0]       i_arrival_time,
    input  logic [jsd_pkg::TAG_W-1:0]       i_job_tag,
    input  logic [jsd_pkg::LEN_W-1:0]       i_job_length,
    input  logic                            i_end_of_batch,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [jsd_pkg::TAG_W-1:0]       o_result_tag,
    output logic [jsd_pkg::CHOICE_W-1:0]    o_server_choice,
    output logic [jsd_pkg::TIME_W-1:0]      o_service_start,
    output logic                            o_last_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jsd_pkg::PADDR_W-1:0]     paddr,
    input  logic [jsd_pkg::PDATA_W-1:0]     pwdata,
    output logic [jsd_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import jsd_pkg::*;

    // configuration register
    logic [ARR_W-1:0] r_close_time;

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_CLOSE_TIME) ?
                    {{(PDATA_W-ARR_W){1'b0}}, r_close_time} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_time <= CLOSE_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[PADDR_W-1] == REG_CLOSE_TIME) begin
            r_close_time <= pwdata[ARR_W-1:0];
        end
    end

    // chain wiring; index MAX_JOBS is the empty tail beyond the last cell
    t_job      cell_job   [MAX_JOBS+1];
    logic      cell_valid [MAX_JOBS+1];
    logic      cell_le    [MAX_JOBS];
    t_job      new_job;
    t_cell_ctl ctl;

    logic r_busy;
    logic in_acc, pop, last_pop, start_batch;

    assign new_job.arrival = i_arrival_time;
    assign new_job.tag     = i_job_tag;
    assign new_job.length  = i_job_length;

    assign o_in_ready  = !r_busy;
    assign in_acc      = i_in_valid && o_in_ready;
    // the last cell being valid means the chain is full
    assign ctl.insert  = in_acc && !i_end_of_batch && (i_job_length != '0) &&
                         !cell_valid[MAX_JOBS-1];
    assign start_batch = in_acc && i_end_of_batch;
    assign pop         = r_busy && (!o_out_valid || i_out_ready);
    assign ctl.pop     = pop;
    assign last_pop    = pop && !cell_valid[1];

    assign cell_job[MAX_JOBS]   = '0;
    assign cell_valid[MAX_JOBS] = 1'b0;

    // busy from batch end until the final job leaves the chain head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (start_batch) begin
            r_busy <= cell_valid[0];
        end else if (last_pop) begin
            r_busy <= 1'b0;
        end
    end

    for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
        if (k == 0) begin : g_head
            jsd_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_new_job   (new_job),
                .i_prev_job  (new_job),
                .i_prev_valid(1'b0),
                .i_prev_le   (1'b1),
                .i_next_job  (cell_job[k+1]),
                .i_next_valid(cell_valid[k+1]),
                .o_job       (cell_job[k]),
                .o_valid     (cell_valid[k]),
                .o_le        (cell_le[k])
            );
        end else begin : g_body
            jsd_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_new_job   (new_job),
                .i_prev_job  (cell_job[k-1]),
                .i_prev_valid(cell_valid[k-1]),
                .i_prev_le   (cell_le[k-1]),
                .i_next_job  (cell_job[k+1]),
                .i_next_valid(cell_valid[k+1]),
                .o_job       (cell_job[k]),
                .o_valid     (cell_valid[k]),
                .o_le        (cell_le[k])
            );
        end
    end

    // head job goes to the server logic; free times reset at batch start
    jsd_server u_server (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (start_batch),
        .i_pop          (pop),
        .i_job          (cell_job[0]),
        .i_last         (!cell_valid[1]),
        .i_close_time   (r_close_time),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_result_tag   (o_result_tag),
        .o_server_choice(o_server_choice),
        .o_service_start(o_service_start),
        .o_last_result  (o_last_result)
    );

endmodule

// ===== design/jsd_checker.sv =====
// ---------------------------------------------------------------------------
// jsd_checker: port-level checks for the job dispatcher
// Watches result codes, stalls and the load/dispatch interlock.
// ---------------------------------------------------------------------------
module jsd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [jsd_pkg::TAG_W-1:0]       o_result_tag,
    input  logic [jsd_pkg::CHOICE_W-1:0]    o_server_choice,
    input  logic [jsd_pkg::TIME_W-1:0]      o_service_start,
    input  logic                            o_last_result,
    input  logic                            pready
);
    import jsd_pkg::*;

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_tag) && $stable(o_service_start))
        else $error("result changed while stalled");

    a_choice_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_server_choice == SRV_FIRST ||
                         o_server_choice == SRV_SECOND ||
                         o_server_choice == SRV_REJECT))
        else $error("bad server code");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_server_choice == SRV_REJECT |-> o_service_start == '0)
        else $error("rejected job with nonzero start");

    // no loading while a batch still has results to come
    a_no_load_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_result |-> !o_in_ready)
        else $error("input ready during dispatch");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind two_server_job_dispatch_core jsd_checker u_jsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_tag   (o_result_tag),
    .o_server_choice(o_server_choice),
    .o_service_start(o_service_start),
    .o_last_result  (o_last_result),
    .pready         (pready)
);

// ===== dv/tb_two_server_job_dispatch_core.sv =====
// ---------------------------------------------------------------------------
// tb_two_server_job_dispatch_core: self-checking bench for the job dispatcher
// Loads job batches over the request channel, predicts the sorted dispatch
// on each batch end and compares every result against that prediction.
// ---------------------------------------------------------------------------
module tb_two_server_job_dispatch_core;

    timeunit 1ns;
    timeprecision 1ps;

    import jsd_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 20;    // insert work left after the last result
    localparam int LONG_HOLD     = 300;   // receiver back-pressure stretch
    localparam int PHASE_ITEMS   = 40;
    localparam int NUM_PHASES    = 8;
    localparam int FULL_BATCH    = MAX_JOBS + 4;

    // second register index: unmapped, writes must be ignored
    localparam logic REG_UNMAPPED = 1'b1;

    typedef struct packed {
        t_job job;
        logic eob;
    } t_dispatch_req;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [CHOICE_W-1:0] server;
        logic [TIME_W-1:0]   start;
        logic                last;
    } t_grant;

    // DUT stimulus, all known from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [ARR_W-1:0]    i_arrival_time = '0;
    logic [TAG_W-1:0]    i_job_tag      = '0;
    logic [LEN_W-1:0]    i_job_length   = '0;
    logic                i_end_of_batch = 1'b0;
    logic                i_out_ready    = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [PADDR_W-1:0]  paddr          = '0;
    logic [PDATA_W-1:0]  pwdata         = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [TAG_W-1:0]    o_result_tag;
    logic [CHOICE_W-1:0] o_server_choice;
    logic [TIME_W-1:0]   o_service_start;
    logic                o_last_result;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    two_server_job_dispatch_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_arrival_time  (i_arrival_time),
        .i_job_tag       (i_job_tag),
        .i_job_length    (i_job_length),
        .i_end_of_batch  (i_end_of_batch),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_tag    (o_result_tag),
        .o_server_choice (o_server_choice),
        .o_service_start (o_service_start),
        .o_last_result   (o_last_result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Dispatch predictor state: stable-sorted job chain, server free times
    // and the close time as last written.
    // -----------------------------------------------------------------------
    t_job             sorted_jobs[$];
    int unsigned      srv0_free;
    int unsigned      srv1_free;
    logic [ARR_W-1:0] close_limit = CLOSE_RESET;

    t_grant           expected_grants[$];   // results owed by the DUT, oldest first
    t_dispatch_req    pending_reqs[$];      // requests not yet driven

    int  err_count      = 0;
    int  cycle_count    = 0;
    int  phase_items    = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    bit  send_idle_en   = 1'b1;
    bit  recv_idle_en   = 1'b1;
    bit  hold_armed     = 1'b0;
    bit  long_hold_done = 1'b0;

    function automatic int unsigned clamp_time(input int unsigned t);
        return (t > TIME_MAX) ? TIME_MAX : t;
    endfunction

    // Apply one accepted request; a batch end turns the chain into results.
    function automatic void plan_dispatch(input t_dispatch_req r);
        int          pos;
        int unsigned a;
        int unsigned d;
        int unsigned start;
        t_grant      g;
        if (!r.eob) begin
            // zero length or full chain: dropped
            if (r.job.length == '0 || sorted_jobs.size() >= MAX_JOBS)
                return;
            // goes behind every job with equal or earlier arrival
            pos = 0;
            while (pos < sorted_jobs.size() && sorted_jobs[pos].arrival <= r.job.arrival)
                pos++;
            sorted_jobs.insert(pos, r.job);
            return;
        end
        foreach (sorted_jobs[i]) begin
            a = sorted_jobs[i].arrival;
            d = sorted_jobs[i].length;
            g.tag  = sorted_jobs[i].tag;
            g.last = (i == sorted_jobs.size() - 1);
            if (a + d > close_limit) begin
                // only arrival + length is tested, not the real start
                g.server = SRV_REJECT;
                start    = 0;
            end else if (a >= srv0_free) begin
                g.server  = SRV_FIRST;
                start     = a;
                srv0_free = clamp_time(a + d);
            end else if (srv0_free <= srv1_free) begin
                g.server  = SRV_FIRST;
                start     = srv0_free;
                srv0_free = clamp_time(srv0_free + d);
            end else if (a >= srv1_free) begin
                g.server  = SRV_SECOND;
                start     = a;
                srv1_free = clamp_time(a + d);
            end else begin
                g.server  = SRV_SECOND;
                start     = srv1_free;
                srv1_free = clamp_time(srv1_free + d);
            end
            g.start = start[TIME_W-1:0];
            expected_grants.push_back(g);
        end
        // empty batch still clears the free times
        sorted_jobs.delete();
        srv0_free = 0;
        srv1_free = 0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want, input logic has_x);
        if (has_x || got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Idle length: mostly none, some short, a few long.
    function automatic int idle_span(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // -----------------------------------------------------------------------
    // Request driver: feeds pending_reqs into the channel, holds valid and
    // payload until taken, predicts each request at its acceptance edge.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dispatch_req cur;
        t_dispatch_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cur.job.arrival = i_arrival_time;
                cur.job.tag     = i_job_tag;
                cur.job.length  = i_job_length;
                cur.eob         = i_end_of_batch;
                plan_dispatch(cur);
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    i_in_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end else if (pending_reqs.size() > 0) begin
                    nxt = pending_reqs.pop_front();
                    i_in_valid     <= 1'b1;
                    i_arrival_time <= nxt.job.arrival;
                    i_job_tag      <= nxt.job.tag;
                    i_job_length   <= nxt.job.length;
                    i_end_of_batch <= nxt.eob;
                    send_gap       <= idle_span(send_idle_en);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off while a big
    // batch is dispatching so the block backs up onto its request side.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        int span;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (hold_armed && !long_hold_done && o_out_valid) begin
            i_out_ready    <= 1'b0;
            stall_left     <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            span = idle_span(recv_idle_en);
            i_out_ready <= (span == 0);
            stall_left  <= (span > 0) ? span - 1 : 0;
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_grants.size() == 0) begin
                report_mismatch($sformatf("unexpected result tag %0d", o_result_tag));
            end else begin
                want = expected_grants.pop_front();
                check_field("result_tag", o_result_tag, want.tag, $isunknown(o_result_tag));
                check_field("server_choice", o_server_choice, want.server,
                            $isunknown(o_server_choice));
                check_field("service_start", o_service_start, want.start,
                            $isunknown(o_service_start));
                check_field("last_result", o_last_result, want.last, $isunknown(o_last_result));
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    task automatic push_job(input int arr, input int tag, input int len);
        t_dispatch_req r;
        r.job.arrival = arr[ARR_W-1:0];
        r.job.tag     = tag[TAG_W-1:0];
        r.job.length  = len[LEN_W-1:0];
        r.eob         = 1'b0;
        pending_reqs.push_back(r);
        phase_items++;
    endtask

    // batch end; the job fields ride along with random content
    task automatic push_end();
        t_dispatch_req r;
        r.job.arrival = $urandom_range(0, 1023);
        r.job.tag     = $urandom_range(0, 255);
        r.job.length  = $urandom_range(0, 1023);
        r.eob         = 1'b1;
        pending_reqs.push_back(r);
        phase_items++;
    endtask

    // random job: arrivals mostly crowded so the servers contend
    task automatic push_random_job(input bit allow_zero);
        int arr;
        int len;
        int r;
        arr = ($urandom_range(0, 99) < 35) ? $urandom_range(0, 1023) : $urandom_range(0, 150);
        r = $urandom_range(0, 99);
        if (allow_zero && r < 6)
            len = 0;
        else if (r < 65)
            len = $urandom_range(1, 60);
        else
            len = $urandom_range(1, 1023);
        if (allow_zero && r >= 97)
            len = $urandom_range(0, 1023);
        push_job(arr, $urandom_range(0, 255), len);
    endtask

    task automatic push_batch(input int n_jobs, input bit allow_zero);
        repeat (n_jobs) push_random_job(allow_zero);
        push_end();
    endtask

    task automatic push_random_batch();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 70)
            n = $urandom_range(1, 12);
        else if (r < 92)
            n = $urandom_range(13, 40);
        else
            n = $urandom_range(60, FULL_BATCH);
        push_batch(n, 1'b1);
        // occasional back-to-back end: empty batch
        if ($urandom_range(0, 99) < 5)
            push_end();
    endtask

    // APB write: setup then access; register is idle-only
    task automatic write_reg(input logic reg_idx, input int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= ($urandom() & ~32'h3FF) | (value & 32'h3FF);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_CLOSE_TIME)
            close_limit = value[ARR_W-1:0];
    endtask

    // all requests taken and all results back, then let inserts finish
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_in_valid || expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin
        int unsigned phase_close[NUM_PHASES];
        phase_close = '{1023, 1023, CLOSE_RESET, 1023, $urandom_range(0, 1023),
                        $urandom_range(300, 1023), $urandom_range(0, 1023), CLOSE_RESET};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, close time still at its reset value.
        push_end();                         // empty batch right out of reset
        push_job(0,    8'h00, 1023);        // rejected, arrival+length over close
        push_job(0,    8'h03, 20);          // equal arrival, stays behind tag 0
        push_job(1023, 8'hFF, 1);           // rejected at top arrival
        push_job(5,    8'hAA, 0);           // zero length: dropped
        push_job(10,   8'h01, 100);         // server 1 at arrival
        push_job(10,   8'h02, 50);          // server 0 after it frees
        push_job(12,   8'h04, 30);
        push_job(15,   8'h05, 5);
        push_job(16,   8'h08, 50);
        push_job(17,   8'h09, 10);          // server 1 after it frees
        push_job(400,  8'h06, 80);          // exactly at close: accepted
        push_job(400,  8'h07, 81);          // one past close: rejected
        push_end();
        wait_drained();

        // Widest close time, field extremes.
        write_reg(REG_CLOSE_TIME, 1023);
        push_job(1023, 8'hFF, 1023);
        push_job(0,    8'hFF, 1023);
        push_job(1023, 8'h5A, 0);
        push_end();
        wait_drained();

        // Close time zero: everything rejected.
        write_reg(REG_CLOSE_TIME, 0);
        push_job(0, 8'h81, 1);
        push_job(0, 8'h7E, 1);
        push_end();
        wait_drained();

        // Write to the unmapped index must leave close time at zero.
        write_reg(REG_UNMAPPED, 700);
        push_job(0, 8'h11, 1);
        push_end();
        wait_drained();

        // Random phases, each with its own close time and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_CLOSE_TIME, phase_close[p]);
            send_idle_en <= (p != 2);       // one phase runs flat out
            recv_idle_en <= (p != 2);
            phase_items = 0;
            if (p == 1)
                push_batch(FULL_BATCH, 1'b0);   // overfills the chain
            if (p == 3) begin
                hold_armed <= 1'b1;
                push_batch(MAX_JOBS, 1'b0);
            end
            while (phase_items < PHASE_ITEMS)
                push_random_batch();
            wait_drained();
        end

        foreach (expected_grants[i])
            report_mismatch($sformatf("result tag %0d never arrived", expected_grants[i].tag));

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
